/* src/rlf_pkg.sv */
package rlf_pkg;

  localparam int LEVEL_W = 12;
  localparam int STRIDE_W = LEVEL_W + 1;
  localparam int CHAN_W = 4;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL = 12'd4095;

  // command codes
  localparam logic [1:0] ACT_SET  = 2'd0;
  localparam logic [1:0] ACT_FADE = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_ANODE_DRIVE  = 2'd0;
  localparam logic [1:0] REG_RED_CHANNEL  = 2'd1;
  localparam logic [1:0] REG_GREEN_CHANNEL = 2'd2;
  localparam logic [1:0] REG_BLUE_CHANNEL = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [12:0] red_level;
    logic [12:0] green_level;
    logic [12:0] blue_level;
    logic [11:0] fade_steps;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  pwm_channel;
    logic [11:0] on_count;
    logic [11:0] off_count;
    logic        last_write;
    logic        fade_running;
  } pwm_wr_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [12:0] v);
    return (v > {1'b0, MAX_LEVEL}) ? MAX_LEVEL : v[LEVEL_W-1:0];
  endfunction

endpackage

/* src/rgb_led_linear_fader.sv */
// Channel  | Dir | Handshake               | Beat
// ---------+-----+-------------------------+-----------------------------------
// cmd      | in  | cmd_valid / cmd_ready   | set, start fade or tick command
// pwm_wr   | out | pwm_valid / pwm_ready   | one PWM channel write (r, g, b)
// apb      | in  | psel/penable/pready     | register access, 4-bit paddr
//
// One command at a time. Set and tick are accepted, then issue 3 write beats.
// Start fade is accepted, then runs a bit-serial restoring divider that forms
// the 12-bit quotients (one quotient bit per step, three channels side by
// side); the ST_STRIDE state then forms the strides, with no output beats. A tick with no
// fade running and the unused action code are dropped in ST_IDLE.
// Stalls on pwm_ready hold the write beat and keep cmd_ready low.
// rst is synchronous, active high; it clears control and level state.
module rgb_led_linear_fader (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  rlf_pkg::cmd_t         cmd,
  output logic                  pwm_valid,
  input  logic                  pwm_ready,
  output rlf_pkg::pwm_wr_t      pwm_wr,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int LW = rlf_pkg::LEVEL_W;
  localparam int SW = rlf_pkg::STRIDE_W;
  localparam int CW = rlf_pkg::CHAN_W;

  // controller states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_STRIDE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  localparam logic [3:0] DIV_LAST = 4'(LW - 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic          anode_drive;
  logic [CW-1:0] red_channel;
  logic [CW-1:0] green_channel;
  logic [CW-1:0] blue_channel;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      anode_drive   <= 1'b0;
      red_channel   <= 4'd0;
      green_channel <= 4'd1;
      blue_channel  <= 4'd2;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rlf_pkg::REG_ANODE_DRIVE:   anode_drive   <= pwdata[0];
        rlf_pkg::REG_RED_CHANNEL:   red_channel   <= pwdata[CW-1:0];
        rlf_pkg::REG_GREEN_CHANNEL: green_channel <= pwdata[CW-1:0];
        rlf_pkg::REG_BLUE_CHANNEL:  blue_channel  <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rlf_pkg::REG_ANODE_DRIVE:   prdata = {31'd0, anode_drive};
      rlf_pkg::REG_RED_CHANNEL:   prdata = {28'd0, red_channel};
      rlf_pkg::REG_GREEN_CHANNEL: prdata = {28'd0, green_channel};
      rlf_pkg::REG_BLUE_CHANNEL:  prdata = {28'd0, blue_channel};
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Fade state
  // ---------------------------------------------------------------------
  logic [1:0]           state;
  logic [1:0]           beat;       // 0 red, 1 green, 2 blue
  logic                 running;    // fade_running of the current burst
  logic                 fade_active;
  logic [LW-1:0]        level  [3];
  logic [LW-1:0]        target [3];
  logic signed [SW-1:0] stride [3];

  // divider state, one lane per color
  logic [3:0]    div_cnt;
  logic [LW-1:0] divisor;
  logic [LW-1:0] rem [3];
  logic [LW-1:0] quo [3];   // dividend shifts out, quotient shifts in
  logic          neg [3];
  logic          nz  [3];

  logic          cmd_fire;
  logic [LW-1:0] lv [3];

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;

  assign lv[0] = rlf_pkg::clamp_level(cmd.red_level);
  assign lv[1] = rlf_pkg::clamp_level(cmd.green_level);
  assign lv[2] = rlf_pkg::clamp_level(cmd.blue_level);

  // start-fade distance per lane
  logic signed [SW-1:0] delta    [3];
  logic [LW-1:0]        dist_mag [3];
  // one restoring step per lane
  logic [LW:0]          trial    [3];
  logic                 ge       [3];
  // tick update per lane
  logic signed [SW-1:0] gap      [3];
  logic [LW-1:0]        gap_mag  [3];
  logic [LW-1:0]        str_mag  [3];
  logic signed [SW-1:0] moved    [3];
  logic [LW-1:0]        tick_lvl [3];
  logic [2:0]           tick_diff;
  logic [2:0]           fade_diff;
  // final stride per lane
  logic signed [SW-1:0] q_s      [3];
  logic signed [SW-1:0] str_fin  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      delta[k]    = $signed({1'b0, lv[k]}) - $signed({1'b0, level[k]});
      dist_mag[k] = delta[k][SW-1] ? LW'(-delta[k]) : delta[k][LW-1:0];
      fade_diff[k] = (delta[k] != '0);

      trial[k] = {rem[k], quo[k][LW-1]};
      ge[k]    = (trial[k] >= {1'b0, divisor});

      gap[k]     = $signed({1'b0, level[k]}) - $signed({1'b0, target[k]});
      gap_mag[k] = gap[k][SW-1] ? LW'(-gap[k]) : gap[k][LW-1:0];
      str_mag[k] = stride[k][SW-1] ? LW'(-stride[k]) : stride[k][LW-1:0];
      moved[k]   = $signed({1'b0, level[k]}) + stride[k];
      tick_lvl[k] = (gap_mag[k] < str_mag[k]) ? target[k] : moved[k][LW-1:0];
      tick_diff[k] = (tick_lvl[k] != target[k]);

      // truncated quotient, at least one step when the channel moves
      q_s[k] = $signed({1'b0, quo[k]});
      if (quo[k] == '0)
        str_fin[k] = nz[k] ? (neg[k] ? -SW'(1) : SW'(1)) : '0;
      else
        str_fin[k] = neg[k] ? -q_s[k] : q_s[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      beat        <= 2'd0;
      running     <= 1'b0;
      fade_active <= 1'b0;
      div_cnt     <= 4'd0;
      for (int k = 0; k < 3; k++) begin
        level[k]  <= '0;
        target[k] <= '0;
        stride[k] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            beat <= 2'd0;
            case (cmd.action)
              rlf_pkg::ACT_SET: begin
                for (int k = 0; k < 3; k++) level[k] <= lv[k];
                fade_active <= 1'b0;
                running     <= 1'b0;
                state       <= ST_EMIT;
              end
              rlf_pkg::ACT_FADE: begin
                for (int k = 0; k < 3; k++) begin
                  target[k] <= lv[k];
                  quo[k]    <= dist_mag[k];
                  rem[k]    <= '0;
                  neg[k]    <= delta[k][SW-1];
                  nz[k]     <= fade_diff[k];
                end
                divisor     <= (cmd.fade_steps == '0) ? LW'(1) : cmd.fade_steps;
                fade_active <= |fade_diff;
                div_cnt     <= 4'd0;
                state       <= ST_DIV;
              end
              rlf_pkg::ACT_TICK: begin
                if (fade_active) begin
                  for (int k = 0; k < 3; k++) level[k] <= tick_lvl[k];
                  fade_active <= |tick_diff;
                  running     <= |tick_diff;
                  state       <= ST_EMIT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          for (int k = 0; k < 3; k++) begin
            rem[k] <= ge[k] ? LW'(trial[k] - {1'b0, divisor}) : trial[k][LW-1:0];
            quo[k] <= {quo[k][LW-2:0], ge[k]};
          end
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == DIV_LAST) state <= ST_STRIDE;
        end
        ST_STRIDE: begin
          for (int k = 0; k < 3; k++) stride[k] <= str_fin[k];
          state <= ST_IDLE;
        end
        ST_EMIT: begin
          if (pwm_ready) begin
            if (beat == 2'd2) state <= ST_IDLE;
            beat <= beat + 2'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Write beat, formed from held state while in ST_EMIT
  // ---------------------------------------------------------------------
  logic [LW-1:0] beat_lvl;
  logic [CW-1:0] beat_chan;

  always_comb begin
    case (beat)
      2'd0:    begin beat_lvl = level[0]; beat_chan = red_channel;   end
      2'd1:    begin beat_lvl = level[1]; beat_chan = green_channel; end
      default: begin beat_lvl = level[2]; beat_chan = blue_channel;  end
    endcase
    pwm_wr.pwm_channel  = beat_chan;
    pwm_wr.on_count     = anode_drive ? beat_lvl : '0;
    pwm_wr.off_count    = anode_drive ? rlf_pkg::MAX_LEVEL
                                      : rlf_pkg::MAX_LEVEL - beat_lvl;
    pwm_wr.last_write   = (beat == 2'd2);
    pwm_wr.fade_running = running;
  end

  assign pwm_valid = (state == ST_EMIT);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd_ready && pwm_valid))
    else $error("command taken while write burst pending");

  a_last_blue: assert property (@(posedge clk) disable iff (rst)
    pwm_valid && pwm_wr.last_write |-> pwm_wr.pwm_channel == blue_channel)
    else $error("last write not on blue channel");

  a_cathode_on: assert property (@(posedge clk) disable iff (rst)
    pwm_valid && !anode_drive |-> pwm_wr.on_count == '0)
    else $error("common-cathode write with nonzero on count");

  a_fade_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd.action == rlf_pkg::ACT_FADE |=> !cmd_ready && !pwm_valid)
    else $error("fade start did not enter divider");

  a_running_active: assert property (@(posedge clk) disable iff (rst)
    pwm_valid && pwm_wr.fade_running |-> fade_active)
    else $error("fade_running without active fade");
`endif

endmodule
